// ===== rtl/fdma_pkg.sv =====
// ----------------------------------------------------------------------------
// fdma_pkg: shared types and constants of the frame-difference motion alarm
// Frame size, memory geometry, payload structs and the confirmation states.
// ----------------------------------------------------------------------------
package fdma_pkg;

    localparam int FRAME_PIXELS = 307200;
    localparam int POS_W        = $clog2(FRAME_PIXELS);
    localparam int CNT_W        = 19;
    localparam int MEM_DEPTH    = 2 * FRAME_PIXELS;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam int PQ_DEPTH     = 4;
    localparam int PQ_AW        = $clog2(PQ_DEPTH);
    localparam int RQ_DEPTH     = 2;
    localparam int RQ_AW        = $clog2(RQ_DEPTH);

    localparam logic [13:0] GRAY_W_R  = 14'd4899;
    localparam logic [13:0] GRAY_W_G  = 14'd9617;
    localparam logic [13:0] GRAY_W_B  = 14'd1868;
    localparam logic [13:0] GRAY_RND  = 14'd8192;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_PIXELS);

    typedef enum logic [7:0] {
        REG_PIX_THR  = 8'd0,
        REG_MOTION   = 8'd1,
        REG_CHG_THR  = 8'd2,
        REG_MISMATCH = 8'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_ONE  = 2'd1,
        CS_TWO  = 2'd2
    } conf_state_t;

    typedef struct packed {
        logic [7:0]       pixel_diff_threshold;
        logic [CNT_W-1:0] motion_pixel_count;
        logic [7:0]       change_diff_threshold;
        logic [CNT_W-1:0] mismatch_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       gray;
        logic [POS_W-1:0] pos;
        logic             last;
    } pix_t;

    typedef struct packed {
        logic             warning;
        logic [15:0]      warning_total;
        logic [1:0]       confirm_state;
        logic [CNT_W-1:0] changed_pixels;
        logic [CNT_W-1:0] mismatch_pixels;
        logic             background_replaced;
    } res_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_MAX) ? c + 1'b1 : c;
    endfunction

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

// ===== rtl/fdma_ram.sv =====
// ----------------------------------------------------------------------------
// fdma_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fdma_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fdma_front.sv =====
// ----------------------------------------------------------------------------
// fdma_front: pixel intake
// Convert each pixel to gray, tag it with its frame position and queue it.
// ----------------------------------------------------------------------------
module fdma_front
    import fdma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] blue,
    input  logic [7:0] green,
    input  logic [7:0] red,
    input  logic       last_of_frame,
    input  logic       q_pop,
    output logic       q_valid,
    output pix_t       q_item
);

    pix_t             q_mem [PQ_DEPTH];
    logic [PQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PQ_AW:0]   count_reg, count_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [21:0]      gray_sum;
    logic             accept;
    pix_t             entry;

    assign full    = (count_reg == (PQ_AW + 1)'(PQ_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];
    assign accept  = push && !full;

    assign gray_sum = 22'(red)   * 22'(GRAY_W_R)
                    + 22'(green) * 22'(GRAY_W_G)
                    + 22'(blue)  * 22'(GRAY_W_B)
                    + 22'(GRAY_RND);

    always_comb
    begin
        entry.gray = gray_sum[21:14];
        entry.pos  = pos_reg;
        entry.last = last_of_frame;
        if (last_of_frame || pos_reg == POS_W'(FRAME_PIXELS - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
        count_next = count_reg + (PQ_AW + 1)'(accept) - (PQ_AW + 1)'(q_pop && q_valid);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                pos_reg    <= pos_next;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/fdma_res_q.sv =====
// ----------------------------------------------------------------------------
// fdma_res_q: result queue
// Two-entry queue that holds frame results until the consumer takes them.
// ----------------------------------------------------------------------------
module fdma_res_q
    import fdma_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  res_t wr_item,
    output logic q_full,
    input  logic pop,
    output logic empty,
    output res_t head
);

    res_t             mem [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RQ_AW:0]   count_reg;
    logic             do_pop;

    assign q_full = (count_reg == (RQ_AW + 1)'(RQ_DEPTH));
    assign empty  = (count_reg == '0);
    assign head   = mem[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_reg + (RQ_AW + 1)'(wr_en) - (RQ_AW + 1)'(do_pop);
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/fdma_back.sv =====
// ----------------------------------------------------------------------------
// fdma_back: difference engine and frame decision
// Read stored background and reference difference, count changed and
// mismatching pixels, and settle the confirmation machine at frame end.
// ----------------------------------------------------------------------------
module fdma_back
    import fdma_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_valid,
    input  pix_t q_item,
    output logic q_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res_item
);

    // read stage
    logic             b_valid_reg;
    pix_t             b_pix_reg;
    // decision stage
    logic             c_valid_reg;
    logic             busy_reg;

    logic             bg_sel_reg, ref_sel_reg, loaded_reg;
    conf_state_t      state_reg, state_next;
    logic [CNT_W-1:0] changed_reg, mismatch_reg;
    logic [15:0]      warn_cnt_reg, warn_cnt_next;

    logic [7:0]       bg_rdata, ref_rdata, diff, ddiff;
    logic [MEM_AW-1:0] bg_raddr, ref_raddr, bg_waddr, ref_waddr;
    logic             bg_we, ref_we;
    logic             moving, still, disagree, warn, replace;

    function automatic logic [MEM_AW-1:0] bank_addr(input logic bank,
                                                    input logic [POS_W-1:0] pos);
        return bank ? MEM_AW'(pos) + MEM_AW'(FRAME_PIXELS) : MEM_AW'(pos);
    endfunction

    // hold the head while a frame end is settling, and hold a last pixel while no result slot is free
    assign q_pop = q_valid && !busy_reg && (!q_item.last || !res_full);

    assign bg_raddr  = bank_addr(bg_sel_reg, q_item.pos);
    assign ref_raddr = bank_addr(ref_sel_reg, q_item.pos);
    assign bg_waddr  = bank_addr(loaded_reg ? !bg_sel_reg : bg_sel_reg, b_pix_reg.pos);
    assign ref_waddr = bank_addr(!ref_sel_reg, b_pix_reg.pos);
    assign bg_we     = b_valid_reg;
    assign ref_we    = b_valid_reg && loaded_reg;
    assign diff      = abs_diff8(b_pix_reg.gray, bg_rdata);
    assign ddiff     = abs_diff8(diff, ref_rdata);

    fdma_ram #(.DEPTH(MEM_DEPTH), .WIDTH(8)) u_bg_ram (
        .clk   (clk),
        .we    (bg_we),
        .waddr (bg_waddr),
        .wdata (b_pix_reg.gray),
        .raddr (bg_raddr),
        .rdata (bg_rdata)
    );

    fdma_ram #(.DEPTH(MEM_DEPTH), .WIDTH(8)) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (diff),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    always_comb
    begin
        moving     = changed_reg > cfg.motion_pixel_count;
        still      = changed_reg < cfg.motion_pixel_count;
        disagree   = mismatch_reg > cfg.mismatch_limit;
        warn       = 1'b0;
        replace    = 1'b0;
        state_next = state_reg;
        if (!loaded_reg)
        begin
            replace = 1'b1;
        end
        else
        begin
            unique case (state_reg)
                CS_IDLE:
                begin
                    if (moving)
                    begin
                        state_next = CS_ONE;
                    end
                end
                CS_ONE:
                begin
                    if (still || (moving && disagree))
                    begin
                        warn       = 1'b1;
                        state_next = CS_IDLE;
                    end
                    else if (moving)
                    begin
                        state_next = CS_TWO;
                    end
                end
                CS_TWO:
                begin
                    if (still || (moving && disagree))
                    begin
                        warn       = 1'b1;
                        state_next = CS_IDLE;
                    end
                    else if (moving)
                    begin
                        replace    = 1'b1;
                        state_next = CS_IDLE;
                    end
                end
                default:
                begin
                    state_next = CS_IDLE;
                end
            endcase
        end
        warn_cnt_next = warn_cnt_reg + 16'(warn);

        res_push                     = c_valid_reg;
        res_item.warning             = warn;
        res_item.warning_total       = warn_cnt_next;
        res_item.confirm_state       = state_next;
        res_item.changed_pixels      = loaded_reg ? changed_reg : '0;
        res_item.mismatch_pixels     = loaded_reg ? mismatch_reg : '0;
        res_item.background_replaced = replace;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_pix_reg <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            bg_sel_reg   <= 1'b0;
            ref_sel_reg  <= 1'b0;
            loaded_reg   <= 1'b0;
            state_reg    <= CS_IDLE;
            changed_reg  <= '0;
            mismatch_reg <= '0;
            warn_cnt_reg <= '0;
        end
        else
        begin
            b_valid_reg <= q_pop;
            c_valid_reg <= b_valid_reg && b_pix_reg.last;
            if (q_pop && q_item.last)
            begin
                busy_reg <= 1'b1;
            end
            if (b_valid_reg && loaded_reg)
            begin
                if (diff > cfg.pixel_diff_threshold)
                begin
                    changed_reg <= sat_inc(changed_reg);
                end
                if (state_reg != CS_IDLE && ddiff > cfg.change_diff_threshold)
                begin
                    mismatch_reg <= sat_inc(mismatch_reg);
                end
            end
            if (c_valid_reg)
            begin
                busy_reg     <= 1'b0;
                changed_reg  <= '0;
                mismatch_reg <= '0;
                warn_cnt_reg <= warn_cnt_next;
                state_reg    <= state_next;
                loaded_reg   <= 1'b1;
                if (loaded_reg && moving)
                begin
                    ref_sel_reg <= !ref_sel_reg;
                end
                if (loaded_reg && replace)
                begin
                    bg_sel_reg <= !bg_sel_reg;
                end
            end
        end
    end

endmodule

// ===== rtl/frame_difference_motion_alarm_top.sv =====
// Path: a frame result passes the pixel queue, the read stage, the decision
// stage and the result queue after its last pixel is accepted.
// Throughput: one pixel per cycle inside a frame; after the last pixel of a
// frame the back end stops taking pixels from the queue while the frame end
// settles and the background and reference RAM banks are reselected, and the
// 4-entry pixel queue absorbs it. Reset: asynchronous, active low; control
// state and registers return to their defaults, RAM contents stay undefined until written (no clear pass).
// ----------------------------------------------------------------------------
// frame_difference_motion_alarm_top: frame-difference motion alarm
// Pixel queue in, gray differencing against stored frames, result queue out.
// ----------------------------------------------------------------------------
module frame_difference_motion_alarm_top
    import fdma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic        last_of_frame,
    output logic        empty,
    input  logic        pop,
    output logic        warning,
    output logic [15:0] warning_total,
    output logic [1:0]  confirm_state,
    output logic [18:0] changed_pixels,
    output logic [18:0] mismatch_pixels,
    output logic        background_replaced,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [18:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_valid, q_pop, res_full, res_push;
    pix_t q_item;
    res_t res_item, res_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_diff_threshold  <= 8'd60;
            cfg_reg.motion_pixel_count    <= CNT_W'(20000);
            cfg_reg.change_diff_threshold <= 8'd20;
            cfg_reg.mismatch_limit        <= CNT_W'(3000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PIX_THR:  cfg_reg.pixel_diff_threshold  <= cfg_data[7:0];
                REG_MOTION:   cfg_reg.motion_pixel_count    <= cfg_data;
                REG_CHG_THR:  cfg_reg.change_diff_threshold <= cfg_data[7:0];
                REG_MISMATCH: cfg_reg.mismatch_limit        <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    fdma_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .blue          (blue),
        .green         (green),
        .red           (red),
        .last_of_frame (last_of_frame),
        .q_pop         (q_pop),
        .q_valid       (q_valid),
        .q_item        (q_item)
    );

    fdma_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_item (res_item)
    );

    fdma_res_q u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_item (res_item),
        .q_full  (res_full),
        .pop     (pop),
        .empty   (empty),
        .head    (res_head)
    );

    assign warning             = res_head.warning;
    assign warning_total       = res_head.warning_total;
    assign confirm_state       = res_head.confirm_state;
    assign changed_pixels      = res_head.changed_pixels;
    assign mismatch_pixels     = res_head.mismatch_pixels;
    assign background_replaced = res_head.background_replaced;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_warn_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && warning) |-> (confirm_state == CS_IDLE))
        else $error("warning result with confirmation not idle");

    a_warn_xor_replace: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(warning && background_replaced))
        else $error("warning and background replacement in one frame");

endmodule
